/* src/bmtr_pkg.sv */
`default_nettype none

package bmtr_pkg;

	// Store geometry
	localparam int STORE_BYTES = 512;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	// Largest row address is 15*31 + 31 = 496, so nine bits cover every read address
	localparam int ACC_W       = 9;

	// Rows gathered per column
	localparam int MAX_ROWS  = 16;
	localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

	// Field widths
	localparam int PIX_W    = 8;
	localparam int COL_W    = 8;
	localparam int WORD_W   = 16;
	localparam int STRIDE_W = 5;

	// Configuration register indexes
	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	// Input actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	// Microcode
	typedef logic [1:0] step_t;

	localparam step_t STEP_IDLE   = 2'd0;
	localparam step_t STEP_GATHER = 2'd1;
	localparam step_t STEP_DRAIN  = 2'd2;
	localparam step_t STEP_EMIT   = 2'd3;

	typedef enum logic [1:0] {
		COND_ALWAYS    = 2'd0,
		COND_FETCH     = 2'd1,
		COND_ROWS_LEFT = 2'd2,
		COND_OUT_FREE  = 2'd3
	} cond_t;

	typedef struct packed {
		logic  accept;
		logic  issue;
		logic  emit;
		cond_t cond;
		step_t on_true;
		step_t on_false;
	} ucode_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic fetch;
		logic rows_left;
		logic out_free;
	} stat_t;

	// Qualified strobes driven into the datapath
	typedef struct packed {
		logic accept;
		logic issue;
		logic emit;
	} ctl_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		begin
			unique case (step)
				STEP_IDLE:   w = '{accept: 1'b1, issue: 1'b0, emit: 1'b0,
					cond: COND_FETCH, on_true: STEP_GATHER, on_false: STEP_IDLE};
				STEP_GATHER: w = '{accept: 1'b0, issue: 1'b1, emit: 1'b0,
					cond: COND_ROWS_LEFT, on_true: STEP_GATHER, on_false: STEP_DRAIN};
				STEP_DRAIN:  w = '{accept: 1'b0, issue: 1'b0, emit: 1'b0,
					cond: COND_ALWAYS, on_true: STEP_EMIT, on_false: STEP_EMIT};
				STEP_EMIT:   w = '{accept: 1'b0, issue: 1'b0, emit: 1'b1,
					cond: COND_OUT_FREE, on_true: STEP_IDLE, on_false: STEP_EMIT};
				default:     w = '{accept: 1'b0, issue: 1'b0, emit: 1'b0,
					cond: COND_ALWAYS, on_true: STEP_IDLE, on_false: STEP_IDLE};
			endcase
			return w;
		end
	endfunction

endpackage

`default_nettype wire

/* src/bmtr_if.sv */
`default_nettype none

interface bmtr_item_if;
	import bmtr_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   action;
	logic [ACC_W-1:0]       byte_index;
	logic [PIX_W-1:0]       byte_value;
	logic [COL_W-1:0]       column_index;

	modport source (output valid, action, byte_index, byte_value, column_index, input ready);
	modport sink   (input valid, action, byte_index, byte_value, column_index, output ready);
endinterface

interface bmtr_result_if;
	import bmtr_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] column_bits;

	modport source (output valid, column_bits, input ready);
	modport sink   (input valid, column_bits, output ready);
endinterface

`default_nettype wire

/* src/bitmap_row_to_column_transpose.sv */
`default_nettype none

// Write beat: accepted back to back while the sequencer is idle.
// Fetch beat: the sequencer gathers rows = min(height,16) bytes, none for a column
// at or beyond the width, reading the single-port byte store once per row, then
// passes through a drain and an emit step before it takes the next beat in idle;
// a stalled result holds the emit step.
// Reset: width 8, height 16, output empty; the byte store is not cleared.
module bitmap_row_to_column_transpose (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire [0:0]             cfg_index,
	input  wire [bmtr_pkg::PIX_W-1:0] cfg_data,
	bmtr_item_if.sink             req,
	bmtr_result_if.source         rsp
);
	import bmtr_pkg::*;

	stat_t stat;
	ctl_t  ctl;

	logic [PIX_W-1:0]     width_q;
	logic [PIX_W-1:0]     height_q;

	logic [PIX_W-1:0]     mem [STORE_BYTES];

	logic [ACC_W-1:0]     acc_q;
	logic [ROW_CNT_W-1:0] row_q;
	logic [ROW_CNT_W-1:0] rows_q;
	logic [STRIDE_W-1:0]  stride_q;
	logic [2:0]           bitpos_q;
	logic                 col_ok_q;
	logic [WORD_W-1:0]    word_q;

	logic                 pend_s1;
	logic                 rd_ok_s1;
	logic [ROW_W-1:0]     prow_s1;
	logic [PIX_W-1:0]     rd_data_s1;

	logic                 out_valid_q;
	logic [WORD_W-1:0]    column_bits_q;

	logic                 beat_in;
	logic                 fetch_in;
	logic                 write_in;
	logic [STRIDE_W-1:0]  stride_d;
	logic [ROW_CNT_W-1:0] rows_d;
	logic [2:0]           bitpos_d;

	assign beat_in  = req.valid & req.ready;
	assign fetch_in = beat_in & (req.action == ACT_FETCH);
	assign write_in = beat_in & (req.action == ACT_WRITE);

	assign stat.fetch     = req.valid & (req.action == ACT_FETCH);
	assign stat.rows_left = col_ok_q & (row_q < rows_q);
	assign stat.out_free  = ~out_valid_q | rsp.ready;

	bmtr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	assign req.ready       = ctl.accept;
	assign rsp.valid       = out_valid_q;
	assign rsp.column_bits = column_bits_q;

	// Row stride is width/8, floored at one byte
	always_comb begin
		stride_d = STRIDE_W'(width_q >> 3);
		if (stride_d == '0) begin
			stride_d = STRIDE_W'(1);
		end
		if (height_q < PIX_W'(MAX_ROWS)) begin
			rows_d = ROW_CNT_W'(height_q);
		end else begin
			rows_d = ROW_CNT_W'(MAX_ROWS);
		end
		// Narrow bitmaps are right-aligned in the byte
		if (width_q < PIX_W'(8)) begin
			bitpos_d = width_q[2:0] - 3'd1 - req.column_index[2:0];
		end else begin
			bitpos_d = 3'd7 - req.column_index[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= PIX_W'(8);
			height_q <= PIX_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Byte store: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (write_in && (32'(req.byte_index) < STORE_BYTES)) begin
			mem[ADDR_W'(req.byte_index)] <= req.byte_value;
		end
		if (ctl.issue) begin
			rd_data_s1 <= mem[ADDR_W'(acc_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			row_q       <= '0;
			col_ok_q    <= 1'b0;
		end else begin
			pend_s1 <= ctl.issue;
			if (fetch_in) begin
				row_q    <= '0;
				col_ok_q <= req.column_index < width_q;
			end else if (ctl.issue) begin
				row_q <= row_q + ROW_CNT_W'(1);
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_in) begin
			acc_q    <= ACC_W'(req.column_index >> 3);
			rows_q   <= rows_d;
			stride_q <= stride_d;
			bitpos_q <= bitpos_d;
		end else if (ctl.issue) begin
			acc_q <= acc_q + ACC_W'(stride_q);
		end
		if (ctl.issue) begin
			prow_s1  <= row_q[ROW_W-1:0];
			rd_ok_s1 <= 32'(acc_q) < STORE_BYTES;
		end
		// Clear on accept, then drop one pixel per returned read
		if (fetch_in) begin
			word_q <= '0;
		end else if (pend_s1) begin
			word_q[prow_s1] <= rd_data_s1[bitpos_q] & rd_ok_s1;
		end
		if (ctl.emit) begin
			column_bits_q <= word_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.accept && ctl.emit))
		else $error("input accepted while result emitted");

	a_emit_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !pend_s1)
		else $error("result emitted with a read still in flight");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_CNT_W'(MAX_ROWS))
		else $error("row counter ran past the row limit");

	a_fetch_clears_word: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_in |=> (word_q == '0) && !pend_s1)
		else $error("column word not cleared on fetch");
`endif

endmodule

`default_nettype wire

/* src/bmtr_seq.sv */
`default_nettype none

module bmtr_seq (
	input  wire             clk,
	input  wire             arst_n,
	input  wire bmtr_pkg::stat_t stat,
	output bmtr_pkg::ctl_t  ctl
);
	import bmtr_pkg::*;

	step_t  step_q;
	ucode_t uc;
	logic   take;

	assign uc = ucode_rom(step_q);

	always_comb begin
		case (uc.cond)
			COND_ALWAYS:    take = 1'b1;
			COND_FETCH:     take = stat.fetch;
			COND_ROWS_LEFT: take = stat.rows_left;
			COND_OUT_FREE:  take = stat.out_free;
			default:        take = 1'b0;
		endcase
	end

	assign ctl.accept = uc.accept;
	assign ctl.issue  = uc.issue & stat.rows_left;
	assign ctl.emit   = uc.emit & stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= take ? uc.on_true : uc.on_false;
		end
	end

endmodule

`default_nettype wire
